// ----- sv/min_queue_two_stack_top_assert.svh -----
// ---------------------------------------------------------------------------
// min_queue_two_stack_top_assert.svh
// assertion macros for the min queue block
// ---------------------------------------------------------------------------
`ifndef MIN_QUEUE_TWO_STACK_TOP_ASSERT_SVH
`define MIN_QUEUE_TWO_STACK_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// property holds on every edge outside reset
`define MQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition implies consequence on the next edge
`define MQ_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) else $error(msg);
`else
`define MQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define MQ_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg)
`endif

`endif

// ----- sv/mq_pkg.sv -----
// ---------------------------------------------------------------------------
// mq_pkg
// shared types and constants of the min queue
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mq_pkg;

  localparam int DEPTH = 1024;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH) + 1;

  typedef enum logic [2:0] {
    MODE_ENQ   = 3'd0,
    MODE_DEQ   = 3'd1,
    MODE_FRONT = 3'd2,
    MODE_SIZE  = 3'd3,
    MODE_CLEAR = 3'd4,
    MODE_MIN   = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_ERR = 2'd1,
    ST_VAL = 2'd2
  } status_code_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] value_res;
  } out_item_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_ENQ,
    CMD_CLEAR,
    CMD_SIZE,
    CMD_ERR,
    CMD_FILL_START,
    CMD_FILL_STEP,
    CMD_DEQ_RES,
    CMD_FRONT_RES,
    CMD_MIN_RES
  } cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       in_empty;
    logic       out_empty;
    logic       full;
    logic       fill_last;
  } dp_status_t;

endpackage

// ----- sv/min_queue_two_stack_top.sv -----
// ---------------------------------------------------------------------------
// min_queue_two_stack_top
// fifo of signed 32-bit values that also reports the minimum it holds
// ---------------------------------------------------------------------------
// a command is taken when start is high and busy is low; each command gives
// exactly one result, shown for one cycle with out_valid high, and the
// receiver cannot stall it. enqueue, size, clear and error cases pass from
// decode straight to the result register. dequeue, front and min also go
// through the top read and wait states, and dequeue and front add one fill
// step per entry when the out stack is empty and the in stack has to be
// copied across (in stack ram read port, one entry a cycle).
// the stacks live in rams and need no clearing after reset.
`timescale 1ns / 1ps
`include "min_queue_two_stack_top_assert.svh"

module min_queue_two_stack_top import mq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  cmd_t       cmd;
  dp_status_t st;

  // sequencer: decides each step from the datapath flags
  mq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .st    (st),
    .busy  (busy),
    .cmd   (cmd)
  );

  // counts, stack rams and the result register
  mq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .st        (st),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // a transfer always moves the sequencer out of idle
  `MQ_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accept did not raise busy")
  // one result per command, never two in a row
  `MQ_ASSERT_NEXT(a_single_result, clk, rst_n, out_valid, !out_valid, "back to back results")
  // ok and error results carry a zero value
  `MQ_ASSERT(a_zero_value, clk, rst_n, (out_valid && out_data.status != ST_VAL) |-> (out_data.value_res == '0), "non-zero value without value status")

endmodule

// ----- sv/mq_ram.sv -----
// ---------------------------------------------------------------------------
// mq_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/mq_ctrl.sv -----
// ---------------------------------------------------------------------------
// mq_ctrl
// sequencer of the min queue: decode, refill loop, top read
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mq_ctrl import mq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  dp_status_t st,
  output logic       busy,
  output cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FILL,
    S_TOP,
    S_WAIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd       = CMD_LATCH;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_IDLE;
        case (st.mode)
          MODE_ENQ:   cmd = st.full ? CMD_ERR : CMD_ENQ;
          MODE_DEQ, MODE_FRONT: begin
            if (!st.out_empty) begin
              state_nxt = S_TOP;
            end else if (!st.in_empty) begin
              cmd       = CMD_FILL_START;
              state_nxt = S_FILL;
            end else begin
              cmd = CMD_ERR;
            end
          end
          MODE_SIZE:  cmd = CMD_SIZE;
          MODE_CLEAR: cmd = CMD_CLEAR;
          MODE_MIN: begin
            if (st.in_empty && st.out_empty) begin
              cmd = CMD_ERR;
            end else begin
              state_nxt = S_TOP;
            end
          end
          default:    cmd = CMD_ERR;
        endcase
      end
      S_FILL: begin
        cmd = CMD_FILL_STEP;
        if (st.fill_last) begin
          state_nxt = S_TOP;
        end
      end
      // out ram address follows the count, read lands next cycle
      S_TOP: state_nxt = S_WAIT;
      S_WAIT: begin
        state_nxt = S_IDLE;
        case (st.mode)
          MODE_DEQ:   cmd = CMD_DEQ_RES;
          MODE_FRONT: cmd = CMD_FRONT_RES;
          default:    cmd = CMD_MIN_RES;
        endcase
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ----- sv/mq_dp.sv -----
// ---------------------------------------------------------------------------
// mq_dp
// datapath of the min queue: counts, stack memories, result register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mq_dp import mq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       cmd,
  input  in_item_t   in_data,
  output dp_status_t st,
  output logic       out_valid,
  output out_item_t  out_data
);

  logic [CW-1:0]      in_cnt_r, out_cnt_r;
  logic [CW-1:0]      wr_idx_r;
  logic [AW-1:0]      rd_ptr_r;
  logic [2:0]         mode_r;
  logic signed [31:0] value_r;
  logic signed [31:0] in_min_r;
  logic signed [31:0] fill_min_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic [CW-1:0]      in_top, out_top;
  logic [CW:0]        total;
  logic [AW-1:0]      in_raddr;
  logic signed [31:0] in_rdata, out_rdata, omin_rdata;
  logic signed [31:0] step_min, min_res;
  logic               fill_we;

  assign in_top = in_cnt_r - CW'(1);
  assign out_top = out_cnt_r - CW'(1);
  assign total = {1'b0, in_cnt_r} + {1'b0, out_cnt_r};

  assign st.mode      = mode_r;
  assign st.in_empty  = (in_cnt_r == '0);
  assign st.out_empty = (out_cnt_r == '0);
  assign st.full      = (total >= (CW+1)'(DEPTH));
  assign st.fill_last = (wr_idx_r == in_top);

  assign in_raddr = (cmd == CMD_FILL_START) ? in_top[AW-1:0] : rd_ptr_r;
  assign fill_we  = (cmd == CMD_FILL_STEP);
  // running minimum along the reversed copy
  assign step_min = (wr_idx_r == '0) ? in_rdata :
                    ((in_rdata < fill_min_r) ? in_rdata : fill_min_r);

  always_comb begin
    if (in_cnt_r == '0) begin
      min_res = omin_rdata;
    end else if (out_cnt_r == '0) begin
      min_res = in_min_r;
    end else begin
      min_res = (in_min_r < omin_rdata) ? in_min_r : omin_rdata;
    end
  end

  mq_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_in_ram (
    .clk   (clk),
    .we    (cmd == CMD_ENQ),
    .waddr (in_cnt_r[AW-1:0]),
    .wdata (value_r),
    .raddr (in_raddr),
    .rdata (in_rdata)
  );

  mq_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_out_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (wr_idx_r[AW-1:0]),
    .wdata (in_rdata),
    .raddr (out_top[AW-1:0]),
    .rdata (out_rdata)
  );

  mq_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_out_min_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (wr_idx_r[AW-1:0]),
    .wdata (step_min),
    .raddr (out_top[AW-1:0]),
    .rdata (omin_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_cnt_r    <= '0;
      out_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (cmd)
        CMD_ENQ: begin
          in_cnt_r    <= in_cnt_r + CW'(1);
          out_valid_r <= 1'b1;
        end
        CMD_CLEAR: begin
          in_cnt_r    <= '0;
          out_cnt_r   <= '0;
          out_valid_r <= 1'b1;
        end
        CMD_FILL_STEP: begin
          if (st.fill_last) begin
            out_cnt_r <= in_cnt_r;
            in_cnt_r  <= '0;
          end
        end
        CMD_DEQ_RES: begin
          out_cnt_r   <= out_top;
          out_valid_r <= 1'b1;
        end
        CMD_SIZE, CMD_ERR, CMD_FRONT_RES, CMD_MIN_RES: out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LATCH: begin
        mode_r  <= in_data.mode;
        value_r <= in_data.value;
      end
      CMD_ENQ: begin
        in_min_r <= (in_cnt_r == '0 || value_r < in_min_r) ? value_r : in_min_r;
        out_data_r <= '{status: ST_OK, value_res: '0};
      end
      CMD_CLEAR: out_data_r <= '{status: ST_OK, value_res: '0};
      CMD_ERR:   out_data_r <= '{status: ST_ERR, value_res: '0};
      CMD_SIZE:  out_data_r <= '{status: ST_VAL, value_res: 32'(total)};
      CMD_FILL_START: begin
        wr_idx_r <= '0;
        rd_ptr_r <= in_top[AW-1:0] - AW'(1);
      end
      CMD_FILL_STEP: begin
        wr_idx_r   <= wr_idx_r + CW'(1);
        rd_ptr_r   <= rd_ptr_r - AW'(1);
        fill_min_r <= step_min;
      end
      CMD_DEQ_RES, CMD_FRONT_RES: out_data_r <= '{status: ST_VAL, value_res: out_rdata};
      CMD_MIN_RES: out_data_r <= '{status: ST_VAL, value_res: min_res};
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- bench/tb_min_queue_two_stack_top.sv -----
// ---------------------------------------------------------------------------
// tb_min_queue_two_stack_top
// self-checking bench for the min queue built from two stacks
// ---------------------------------------------------------------------------
// commands are driven with random gaps and compared, field by field, with a
// queue-based predictor that tracks content, count and minimum; directed
// cases cover the empty and full queue, unused modes and value extremes
`timescale 1ns / 1ps

// predictor and store of expected results
class mq_scoreboard;
  logic signed [31:0] contents[$];   // oldest entry at index 0
  mq_pkg::out_item_t  pending[$];
  int                 errors;

  function new();
    errors = 0;
  endfunction

  // note an accepted command and work out its result
  function void note_command(mq_pkg::in_item_t cmd);
    mq_pkg::out_item_t  res;
    logic signed [31:0] lowest;
    res.status    = mq_pkg::ST_ERR;
    res.value_res = '0;
    case (cmd.mode)
      mq_pkg::MODE_ENQ: begin
        if (contents.size() < mq_pkg::DEPTH) begin
          contents.push_back(cmd.value);
          res.status = mq_pkg::ST_OK;
        end
      end
      mq_pkg::MODE_DEQ: begin
        if (contents.size() != 0) begin
          res.value_res = contents.pop_front();
          res.status    = mq_pkg::ST_VAL;
        end
      end
      mq_pkg::MODE_FRONT: begin
        if (contents.size() != 0) begin
          res.value_res = contents[0];
          res.status    = mq_pkg::ST_VAL;
        end
      end
      mq_pkg::MODE_SIZE: begin
        res.value_res = contents.size();
        res.status    = mq_pkg::ST_VAL;
      end
      mq_pkg::MODE_CLEAR: begin
        contents.delete();
        res.status = mq_pkg::ST_OK;
      end
      mq_pkg::MODE_MIN: begin
        if (contents.size() != 0) begin
          lowest = contents[0];
          foreach (contents[i])
            if (contents[i] < lowest) lowest = contents[i];
          res.value_res = lowest;
          res.status    = mq_pkg::ST_VAL;
        end
      end
      default: ;
    endcase
    pending.push_back(res);
  endfunction

  function void check_result(mq_pkg::out_item_t got);
    mq_pkg::out_item_t want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result status=%0d value=%0d", $time, got.status,
               got.value_res);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.status !== want.status) begin
      $display("%0t: status mismatch expected %0d actual %0d", $time, want.status,
               got.status);
      errors++;
    end
    if (got.value_res !== want.value_res) begin
      $display("%0t: value mismatch expected %0d actual %0d", $time,
               want.value_res, got.value_res);
      errors++;
    end
  endfunction
endclass

module tb_min_queue_two_stack_top;
  import mq_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_valid;
  out_item_t out_data;

  mq_scoreboard sb;
  int           quiet_cycles;
  bit           gaps_on;
  bit           timed_out;

  min_queue_two_stack_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // sample at the rising edge: command transfer, result transfer, watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_command(in_data);
      if (out_valid) sb.check_result(out_data);
      if ((start && !busy) || out_valid) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) timed_out = 1'b1;
  end

  // present one command at the falling edge and hold it until transferred;
  // start stays high after the transfer edge, busy masks it until the next
  // command or a drain takes it down
  task automatic send_command(input logic [2:0] mode, input logic signed [31:0] value);
    int gap;
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start         <= 1'b1;
    in_data.mode  <= mode;
    in_data.value <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 4))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return $signed($urandom_range(0, 20)) - 10;
      default: return $urandom;
    endcase
  endfunction

  // random mode with a bias that keeps the queue busy but not always full
  function automatic logic [2:0] pick_mode(int enq_weight);
    int r;
    r = $urandom_range(0, 99);
    if (r < enq_weight) return MODE_ENQ;
    if (r < enq_weight + 20) return MODE_DEQ;
    if (r < enq_weight + 27) return MODE_FRONT;
    if (r < enq_weight + 33) return MODE_MIN;
    if (r < enq_weight + 37) return MODE_SIZE;
    if (r < enq_weight + 39) return MODE_CLEAR;
    return 3'($urandom_range(6, 7));
  endfunction

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending.size() != 0 && !timed_out) @(negedge clk);
  endtask

  initial begin
    sb           = new();
    quiet_cycles = 0;
    timed_out    = 1'b0;
    gaps_on      = 1'b0;
    start        = 1'b0;
    in_data      = '0;
    rst_n        = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    fork
      begin
        // directed: empty queue errors, unused modes, extremes of the value
        send_command(MODE_DEQ, 0);
        send_command(MODE_FRONT, 0);
        send_command(MODE_MIN, 0);
        send_command(MODE_SIZE, 0);
        send_command(3'd6, 32'sh7fffffff);
        send_command(3'd7, -1);
        send_command(MODE_ENQ, 32'sh7fffffff);
        send_command(MODE_ENQ, 32'sh80000000);
        send_command(MODE_ENQ, -1);
        send_command(MODE_ENQ, 0);
        send_command(MODE_MIN, 0);
        send_command(MODE_FRONT, 0);
        send_command(MODE_DEQ, 0);
        send_command(MODE_ENQ, 5);
        send_command(MODE_MIN, 0);
        send_command(MODE_DEQ, 0);
        send_command(MODE_MIN, 0);
        send_command(MODE_SIZE, 0);
        send_command(MODE_CLEAR, 0);
        send_command(MODE_SIZE, 0);
        send_command(MODE_MIN, 0);
        drain_results();

        // fill to the full mark, push over it, then refill across a full stack
        for (int i = 0; i < DEPTH + 2; i++) send_command(MODE_ENQ, pick_value());
        send_command(MODE_SIZE, 0);
        send_command(MODE_MIN, 0);
        send_command(MODE_DEQ, 0);
        send_command(MODE_ENQ, $urandom);
        send_command(MODE_ENQ, $urandom);
        for (int i = 0; i < 40; i++) send_command(MODE_DEQ, 0);
        send_command(MODE_MIN, 0);
        send_command(MODE_CLEAR, 0);

        // random with gaps
        gaps_on = 1'b1;
        for (int i = 0; i < 300; i++) begin
          send_command(pick_mode(i < 150 ? 50 : 30), pick_value());
          if (i == 200) drain_results();  // sender holds until all results are in
        end
        // last part without gaps
        gaps_on = 1'b0;
        for (int i = 0; i < 150; i++) send_command(pick_mode(40), pick_value());
        drain_results();
        repeat (20) @(negedge clk);
      end
      begin
        wait (timed_out);
      end
    join_any

    if (timed_out) begin
      $display("Some tests failed");
    end else if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- min_queue_two_stack_top.f -----
+incdir+sv
sv/mq_pkg.sv
sv/mq_ram.sv
sv/mq_ctrl.sv
sv/mq_dp.sv
sv/min_queue_two_stack_top.sv
bench/tb_min_queue_two_stack_top.sv
